>>> rtl/core/gcel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcel_pkg
// Shared widths, default sizes and codes for the grid cell entity lists.
// ----------------------------------------------------------------------------
package gcel_pkg;

   localparam int ENTITY_COUNT_DEF = 64;
   localparam int GRID_WIDTH_DEF   = 32;
   localparam int GRID_HEIGHT_DEF  = 32;

   localparam int KIND_W   = 2;
   localparam int ENTITY_W = 6;
   localparam int COORD_W  = 5;
   localparam int STATUS_W = 3;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_ADD    = 2'd0;
   localparam kind_type KIND_MOVE   = 2'd1;
   localparam kind_type KIND_REMOVE = 2'd2;
   localparam kind_type KIND_SPARE  = 2'd3;

   localparam status_type ST_DONE       = 3'd0;
   localparam status_type ST_ALREADY    = 3'd1;
   localparam status_type ST_NOT_PLACED = 3'd2;
   localparam status_type ST_NOTHING    = 3'd3;
   localparam status_type ST_OFF_GRID   = 3'd4;
   localparam status_type ST_CORRUPT    = 3'd5;

endpackage
`default_nettype wire

>>> rtl/core/gcel_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcel_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gcel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/grid_cell_entity_lists.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_cell_entity_lists
// A refused request goes straight to its result. An add reads the cell head
// and pushes the entity; a remove reads the entity and its old cell head,
// walks past the k entities ahead of it there and unlinks it; a move removes
// and then adds. One item at a time; the next beat is taken the cycle after
// the result is registered. The list walk (one entity RAM read per step) sets
// the rate. After reset the cell head RAM is swept with req_stall high.
// ----------------------------------------------------------------------------
module grid_cell_entity_lists #(
   parameter int ENTITY_COUNT = gcel_pkg::ENTITY_COUNT_DEF,
   parameter int GRID_WIDTH   = gcel_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT  = gcel_pkg::GRID_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [gcel_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [gcel_pkg::ENTITY_W-1:0]     req_entity,
   input  wire logic [gcel_pkg::COORD_W-1:0]      req_x,
   input  wire logic [gcel_pkg::COORD_W-1:0]      req_y,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [gcel_pkg::STATUS_W-1:0]          rsp_status
);

   localparam int CRW        = gcel_pkg::COORD_W;
   localparam int EW         = $clog2(ENTITY_COUNT);
   localparam int LW         = $clog2(ENTITY_COUNT + 1);
   localparam int XW         = (LW > gcel_pkg::ENTITY_W) ? LW : gcel_pkg::ENTITY_W;
   localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
   localparam int CW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int WW         = 2 * CRW + LW;

   localparam logic [LW-1:0] LINK_NONE = LW'(ENTITY_COUNT);
   localparam logic [CW-1:0] CELL_LAST = CW'(CELL_COUNT - 1);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_PUSH_RD = 4'd2;
   localparam logic [3:0] S_PUSH_WR = 4'd3;
   localparam logic [3:0] S_ENT_RD  = 4'd4;
   localparam logic [3:0] S_ENT_GOT = 4'd5;
   localparam logic [3:0] S_HEAD    = 4'd6;
   localparam logic [3:0] S_WALK    = 4'd7;
   localparam logic [3:0] S_WALK_RD = 4'd8;
   localparam logic [3:0] S_FINISH  = 4'd9;

   function automatic logic [CW-1:0] cell_of(input logic [CRW-1:0] col,
                                             input logic [CRW-1:0] row);
      return CW'(16'(col) * 16'(GRID_HEIGHT) + 16'(row));
   endfunction

   // control registers
   logic [3:0]              state_ff, state_in;
   logic [CW-1:0]           clr_ff, clr_in;
   logic [ENTITY_COUNT-1:0] placed_ff, placed_in;
   logic [ENTITY_COUNT-1:0] link_ok_ff, link_ok_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // working registers
   gcel_pkg::kind_type      kind_ff, kind_in;
   logic [EW-1:0]           ent_ff, ent_in;
   logic [CRW-1:0]          x_ff, x_in, y_ff, y_in;
   gcel_pkg::status_type    status_ff, status_in;
   gcel_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [LW-1:0]           e_link_ff, e_link_in;
   logic [CW-1:0]           old_cell_ff, old_cell_in;
   logic [LW-1:0]           cur_ff, cur_in, prev_ff, prev_in, steps_ff, steps_in;
   logic [CRW-1:0]          prev_col_ff, prev_col_in, prev_row_ff, prev_row_in;
   logic                    ent_ok_ff;

   // memory ports
   logic          cell_wr_en, cell_rd_en;
   logic [CW-1:0] cell_wr_addr, cell_rd_addr;
   logic [LW-1:0] cell_wr_data, cell_rd_data;
   logic          ent_wr_en, ent_rd_en;
   logic [EW-1:0] ent_wr_addr, ent_rd_addr;
   logic [WW-1:0] ent_wr_data, ent_rd_data;

   // request decode
   logic [XW-1:0]  ent_ext;
   logic           in_pool, on_grid, placed_req;
   logic [EW-1:0]  req_ix;
   logic [CW-1:0]  new_cell;
   logic [CRW-1:0] rd_col, rd_row;
   logic [LW-1:0]  rd_link;

   assign ent_ext    = XW'(req_entity);
   assign in_pool    = ent_ext < XW'(ENTITY_COUNT);
   assign req_ix     = ent_ext[EW-1:0];
   assign placed_req = in_pool && placed_ff[req_ix];
   assign on_grid    = (9'(req_x) < 9'(GRID_WIDTH)) && (9'(req_y) < 9'(GRID_HEIGHT));
   assign new_cell   = cell_of(x_ff, y_ff);

   assign rd_col  = ent_rd_data[WW-1 -: CRW];
   assign rd_row  = ent_rd_data[LW +: CRW];
   assign rd_link = ent_ok_ff ? ent_rd_data[LW-1:0] : LINK_NONE;

   gcel_ram #(
      .WIDTH (LW),
      .DEPTH (CELL_COUNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_en   (cell_rd_en),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_data)
   );

   gcel_ram #(
      .WIDTH (WW),
      .DEPTH (ENTITY_COUNT)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      placed_in     = placed_ff;
      link_ok_in    = link_ok_ff;
      kind_in       = kind_ff;
      ent_in        = ent_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      status_in     = status_ff;
      e_link_in     = e_link_ff;
      old_cell_in   = old_cell_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      prev_col_in   = prev_col_ff;
      prev_row_in   = prev_row_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      cell_wr_en   = 1'b0;
      cell_wr_addr = new_cell;
      cell_wr_data = LW'(ent_ff);
      cell_rd_en   = 1'b0;
      cell_rd_addr = new_cell;
      ent_wr_en    = 1'b0;
      ent_wr_addr  = ent_ff;
      ent_wr_data  = {x_ff, y_ff, cell_rd_data};
      ent_rd_en    = 1'b0;
      ent_rd_addr  = ent_ff;

      unique case (state_ff)
         S_CLEAR: begin
            cell_wr_en   = 1'b1;
            cell_wr_addr = clr_ff;
            cell_wr_data = LINK_NONE;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == CELL_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               ent_in  = req_ix;
               x_in    = req_x;
               y_in    = req_y;
               priority if (req_kind == gcel_pkg::KIND_ADD ||
                            req_kind == gcel_pkg::KIND_MOVE) begin
                  if (!in_pool || !on_grid) begin
                     status_in = gcel_pkg::ST_OFF_GRID;
                     state_in  = S_FINISH;
                  end else if (req_kind == gcel_pkg::KIND_ADD) begin
                     if (placed_req) begin
                        status_in = gcel_pkg::ST_ALREADY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_PUSH_RD;
                     end
                  end else if (!placed_req) begin
                     status_in = gcel_pkg::ST_NOT_PLACED;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_ENT_RD;
                  end
               end else if (req_kind == gcel_pkg::KIND_REMOVE && placed_req) begin
                  state_in = S_ENT_RD;
               end else begin
                  status_in = gcel_pkg::ST_NOTHING;
                  state_in  = S_FINISH;
               end
            end
         end
         S_PUSH_RD: begin
            cell_rd_en = 1'b1;
            state_in   = S_PUSH_WR;
         end
         S_PUSH_WR: begin
            // new head of the target cell
            ent_wr_en          = 1'b1;
            cell_wr_en         = 1'b1;
            link_ok_in[ent_ff] = 1'b1;
            placed_in[ent_ff]  = 1'b1;
            status_in          = gcel_pkg::ST_DONE;
            state_in           = S_FINISH;
         end
         S_ENT_RD: begin
            ent_rd_en = 1'b1;
            state_in  = S_ENT_GOT;
         end
         S_ENT_GOT: begin
            e_link_in    = rd_link;
            old_cell_in  = cell_of(rd_col, rd_row);
            prev_col_in  = rd_col;
            prev_row_in  = rd_row;
            cell_rd_en   = 1'b1;
            cell_rd_addr = cell_of(rd_col, rd_row);
            state_in     = S_HEAD;
         end
         S_HEAD: begin
            cur_in   = cell_rd_data;
            prev_in  = LINK_NONE;
            steps_in = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            priority if (steps_ff == LINK_NONE || cur_ff >= LINK_NONE) begin
               status_in = gcel_pkg::ST_CORRUPT;
               state_in  = S_FINISH;
            end else if (cur_ff == LW'(ent_ff)) begin
               if (prev_ff == LINK_NONE) begin
                  cell_wr_en   = 1'b1;
                  cell_wr_addr = old_cell_ff;
                  cell_wr_data = e_link_ff;
               end else begin
                  ent_wr_en   = 1'b1;
                  ent_wr_addr = prev_ff[EW-1:0];
                  ent_wr_data = {prev_col_ff, prev_row_ff, e_link_ff};
               end
               if (kind_ff == gcel_pkg::KIND_REMOVE) begin
                  placed_in[ent_ff] = 1'b0;
                  status_in         = gcel_pkg::ST_DONE;
                  state_in          = S_FINISH;
               end else begin
                  state_in = S_PUSH_RD;
               end
            end else begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = cur_ff[EW-1:0];
               state_in    = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            prev_in     = cur_ff;
            prev_col_in = rd_col;
            prev_row_in = rd_row;
            cur_in      = rd_link;
            steps_in    = steps_ff + 1'b1;
            state_in    = S_WALK;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         placed_ff    <= '0;
         link_ok_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         placed_ff    <= placed_in;
         link_ok_ff   <= link_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      ent_ff        <= ent_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      e_link_ff     <= e_link_in;
      old_cell_ff   <= old_cell_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      prev_col_ff   <= prev_col_in;
      prev_row_ff   <= prev_row_in;
      if (ent_rd_en) begin
         ent_ok_ff <= link_ok_ff[ent_rd_addr];
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

>>> rtl/core/gcel_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcel_check
// Port-level checks for the grid cell entity lists, bound to the top level.
// ----------------------------------------------------------------------------
module gcel_check (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [gcel_pkg::STATUS_W-1:0] rsp_status
);

   // result beat held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result beat changed");

   // cell sweep keeps the input closed after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> req_stall)
      else $error("input open during cell sweep");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while item in progress");

   // no result without an item
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= gcel_pkg::ST_CORRUPT)
      else $error("undefined status code");

endmodule

bind grid_cell_entity_lists gcel_check u_gcel_check (.*);
`default_nettype wire
